// ===== design/tcbspl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcbspl_pkg
// Shared types and constants for the tcb spline point evaluator: the
// transaction payloads, the configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package tcbspl_pkg;

    // field widths fixed by the data formats
    localparam int COORD_W   = 16;  // signed Q3.12
    localparam int U_W       = 16;  // unsigned Q0.16
    localparam int CFG_W     = 16;  // signed Q1.14
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TENSION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTINUITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 2'd2;

    // 1.0 in Q1.14
    localparam int ONE_Q14 = 16384;

    // input transaction: parameter and four control points
    typedef struct packed {
        logic        [U_W-1:0]     u_param;
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
    } point_t;

    // output transaction: curve point
    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
    } curve_t;

endpackage

// ===== design/tcbspl_if.sv =====
// ----------------------------------------------------------------------------
// tcbspl_if
// Valid/ready stream interfaces for the point and curve channels.
// ----------------------------------------------------------------------------
interface tcbspl_point_if import tcbspl_pkg::*; ();

    logic   valid;
    logic   ready;
    point_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

interface tcbspl_curve_if import tcbspl_pkg::*; ();

    logic   valid;
    logic   ready;
    curve_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/tcb_spline_point_eval.sv =====
// ----------------------------------------------------------------------------
// tcb_spline_point_eval
// Kochanek-Bartels (tension, continuity, bias) Hermite spline point
// evaluator, fixed point, nine register stages.
// ----------------------------------------------------------------------------
// Usage:
//   point: sink channel, one transaction holds u (Q0.16) and the control
//          points P0..P3 (x and y, signed Q3.12).
//   curve: source channel, one transaction per point, the curve x and y at u
//          between P1 and P2 (signed Q3.12, saturated).
//   cfg_write_en/cfg_index/cfg_data: writes tension, continuity and bias
//          (signed Q1.14); an index past the three registers is ignored.
//          Write only while no transaction is in flight.
// Path: a point taken from point passes through nine register stages, the last
//   one being the output register, before it shows up on curve.
// Throughput: one point per cycle while curve is not stalled; the depth is set
//   by the chain of multiplies u*u, u^2*u, weight*difference, (1-t)*g, basis*point and basis*tangent.
// Reset: clears all valid bits and the three registers to zero.
// Stall: each stage holds while its successor is full and not moving, so a
//   stalled curve output backs the pipe up stage by stage; point.ready drops
//   only once every stage is full. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module tcb_spline_point_eval
    import tcbspl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    tcbspl_point_if.sink         point,
    tcbspl_curve_if.source       curve
);

    // internal widths
    localparam int NSTAGE   = 9;
    localparam int U2_W     = 2 * U_W;            // u^2
    localparam int U3_W     = 3 * U_W;            // u^3
    localparam int K_W      = CFG_W + 1;          // 1 +/- register
    localparam int W_W      = 2 * K_W - 1;        // weight, Q28
    localparam int D_W      = COORD_W + 1;        // point difference
    localparam int PROD_W   = W_W + D_W;          // weight * difference
    localparam int SUM_W    = PROD_W + 1;
    localparam int BAS_W    = U3_W + 4;           // basis sum in Q48
    localparam int BASIS_SH = 24;
    localparam int HB_W     = 26;                 // basis, Q24
    localparam int G_SH     = 24;
    localparam int G_W      = 26;                 // tangent sum, Q16
    localparam int KG_W     = K_W + G_W;
    localparam int M_SH     = 15;
    localparam int M_W      = 27;                 // tangent, Q16
    localparam int ACC_W    = 56;                 // accumulator, Q40
    localparam int OUT_SH   = 28;
    localparam int Q_W      = ACC_W - OUT_SH;

    localparam logic signed [K_W-1:0]   ONE_K    = K_W'(ONE_Q14);
    localparam logic signed [BAS_W-1:0] BAS_ONE  = BAS_W'(1) <<< (2 * U3_W / 3 * 1 + U_W);
    localparam logic signed [BAS_W-1:0] BAS_HALF = BAS_W'(1) <<< (BASIS_SH - 1);
    localparam logic signed [SUM_W-1:0] G_HALF   = SUM_W'(1) <<< (G_SH - 1);
    localparam logic signed [KG_W-1:0]  M_HALF   = KG_W'(1) <<< (M_SH - 1);
    localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) <<< (OUT_SH - 1);
    localparam logic signed [Q_W-1:0]   SAT_MAX  = Q_W'(32767);
    localparam logic signed [Q_W-1:0]   SAT_MIN  = -Q_W'(32768);

    // configuration registers and derived weights
    logic [CFG_W-1:0]        tension_reg;
    logic [CFG_W-1:0]        continuity_reg;
    logic [CFG_W-1:0]        bias_reg;
    logic signed [K_W-1:0]   k_reg;
    logic signed [W_W-1:0]   wa_reg, wb_reg, wc_reg, wd_reg;
    logic signed [K_W-1:0]   opb, omb, opc, omc;

    // handshake
    logic [NSTAGE:1] valid_reg;
    logic [NSTAGE:1] adv;

    // stage 1: captured transaction
    logic [U_W-1:0]            s1_u_reg, s1_u_next;
    logic signed [COORD_W-1:0] s1_p_reg [4][2];
    logic signed [COORD_W-1:0] s1_p_next [4][2];

    // stage 2: u^2 and differences
    logic [U_W-1:0]            s2_u_reg, s2_u_next;
    logic [U2_W-1:0]           s2_u2_reg, s2_u2_next;
    logic signed [COORD_W-1:0] s2_p1_reg [2], s2_p1_next [2];
    logic signed [COORD_W-1:0] s2_p2_reg [2], s2_p2_next [2];
    logic signed [D_W-1:0]     s2_d01_reg [2], s2_d01_next [2];
    logic signed [D_W-1:0]     s2_d12_reg [2], s2_d12_next [2];
    logic signed [D_W-1:0]     s2_d23_reg [2], s2_d23_next [2];

    // stage 3: u^3 and weighted differences
    logic [U_W-1:0]            s3_u_reg, s3_u_next;
    logic [U2_W-1:0]           s3_u2_reg, s3_u2_next;
    logic [U3_W-1:0]           s3_u3_reg, s3_u3_next;
    logic signed [COORD_W-1:0] s3_p1_reg [2], s3_p1_next [2];
    logic signed [COORD_W-1:0] s3_p2_reg [2], s3_p2_next [2];
    logic signed [PROD_W-1:0]  s3_pa_reg [2], s3_pa_next [2];
    logic signed [PROD_W-1:0]  s3_pb_reg [2], s3_pb_next [2];
    logic signed [PROD_W-1:0]  s3_pc_reg [2], s3_pc_next [2];
    logic signed [PROD_W-1:0]  s3_pd_reg [2], s3_pd_next [2];

    // stage 4: basis and tangent sums
    logic signed [HB_W-1:0]    s4_hb_reg [4], s4_hb_next [4];
    logic signed [COORD_W-1:0] s4_p1_reg [2], s4_p1_next [2];
    logic signed [COORD_W-1:0] s4_p2_reg [2], s4_p2_next [2];
    logic signed [G_W-1:0]     s4_g1_reg [2], s4_g1_next [2];
    logic signed [G_W-1:0]     s4_g2_reg [2], s4_g2_next [2];
    logic signed [BAS_W-1:0]   bas_u3, bas_u2, bas_u1;
    logic signed [BAS_W-1:0]   bas_sum [4];
    logic signed [SUM_W-1:0]   g1_sum [2], g2_sum [2];

    // stage 5: tension scaling
    logic signed [HB_W-1:0]    s5_hb_reg [4], s5_hb_next [4];
    logic signed [COORD_W-1:0] s5_p1_reg [2], s5_p1_next [2];
    logic signed [COORD_W-1:0] s5_p2_reg [2], s5_p2_next [2];
    logic signed [KG_W-1:0]    s5_kg1_reg [2], s5_kg1_next [2];
    logic signed [KG_W-1:0]    s5_kg2_reg [2], s5_kg2_next [2];

    // stage 6: tangents and point products
    logic signed [HB_W-1:0]    s6_hb2_reg, s6_hb2_next;
    logic signed [HB_W-1:0]    s6_hb3_reg, s6_hb3_next;
    logic signed [M_W-1:0]     s6_m1_reg [2], s6_m1_next [2];
    logic signed [M_W-1:0]     s6_m2_reg [2], s6_m2_next [2];
    logic signed [ACC_W-1:0]   s6_pr0_reg [2], s6_pr0_next [2];
    logic signed [ACC_W-1:0]   s6_pr1_reg [2], s6_pr1_next [2];
    logic signed [KG_W-1:0]    m1_sum [2], m2_sum [2];

    // stage 7: all four products
    logic signed [ACC_W-1:0]   s7_pr_reg [4][2];
    logic signed [ACC_W-1:0]   s7_pr_next [4][2];

    // stage 8: accumulated sum with rounding offset
    logic signed [ACC_W-1:0]   s8_acc_reg [2], s8_acc_next [2];

    // stage 9: output register
    logic signed [COORD_W-1:0] s9_out_reg [2], s9_out_next [2];
    logic signed [Q_W-1:0]     q_val [2];

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg    <= '0;
            continuity_reg <= '0;
            bias_reg       <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_TENSION:    tension_reg    <= cfg_data;
                REG_CONTINUITY: continuity_reg <= cfg_data;
                REG_BIAS:       bias_reg       <= cfg_data;
                default:        ;
            endcase
        end
    end

    // weight factors from the registers
    always_comb
    begin
        opb = ONE_K + K_W'(signed'(bias_reg));
        omb = ONE_K - K_W'(signed'(bias_reg));
        opc = ONE_K + K_W'(signed'(continuity_reg));
        omc = ONE_K - K_W'(signed'(continuity_reg));
    end

    // weights registered, used from stage 3 on
    always_ff @(posedge clk)
    begin
        k_reg  <= ONE_K - K_W'(signed'(tension_reg));
        wa_reg <= W_W'(opb) * W_W'(omc);
        wb_reg <= W_W'(omb) * W_W'(opc);
        wc_reg <= W_W'(opb) * W_W'(opc);
        wd_reg <= W_W'(omb) * W_W'(omc);
    end

    // stage enables: a stage moves when empty or when its successor moves
    always_comb
    begin
        adv[NSTAGE] = !valid_reg[NSTAGE] || curve.ready;
        for (int i = NSTAGE - 1; i >= 1; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign point.ready = adv[1];
    assign curve.valid = valid_reg[NSTAGE];
    assign curve.payload.out_x = s9_out_reg[0];
    assign curve.payload.out_y = s9_out_reg[1];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= point.valid;
            end
            for (int i = 2; i <= NSTAGE; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage 1: capture
    always_comb
    begin
        s1_u_next       = point.payload.u_param;
        s1_p_next[0][0] = point.payload.p0_x;
        s1_p_next[0][1] = point.payload.p0_y;
        s1_p_next[1][0] = point.payload.p1_x;
        s1_p_next[1][1] = point.payload.p1_y;
        s1_p_next[2][0] = point.payload.p2_x;
        s1_p_next[2][1] = point.payload.p2_y;
        s1_p_next[3][0] = point.payload.p3_x;
        s1_p_next[3][1] = point.payload.p3_y;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_u_reg <= s1_u_next;
            s1_p_reg <= s1_p_next;
        end
    end

    // stage 2: u squared, point differences
    always_comb
    begin
        s2_u_next  = s1_u_reg;
        s2_u2_next = U2_W'(s1_u_reg) * U2_W'(s1_u_reg);
        for (int a = 0; a < 2; a++)
        begin
            s2_p1_next[a]  = s1_p_reg[1][a];
            s2_p2_next[a]  = s1_p_reg[2][a];
            s2_d01_next[a] = D_W'(s1_p_reg[1][a]) - D_W'(s1_p_reg[0][a]);
            s2_d12_next[a] = D_W'(s1_p_reg[2][a]) - D_W'(s1_p_reg[1][a]);
            s2_d23_next[a] = D_W'(s1_p_reg[3][a]) - D_W'(s1_p_reg[2][a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_u_reg   <= s2_u_next;
            s2_u2_reg  <= s2_u2_next;
            s2_p1_reg  <= s2_p1_next;
            s2_p2_reg  <= s2_p2_next;
            s2_d01_reg <= s2_d01_next;
            s2_d12_reg <= s2_d12_next;
            s2_d23_reg <= s2_d23_next;
        end
    end

    // stage 3: u cubed, weighted differences
    always_comb
    begin
        s3_u_next  = s2_u_reg;
        s3_u2_next = s2_u2_reg;
        s3_u3_next = U3_W'(s2_u2_reg) * U3_W'(s2_u_reg);
        for (int a = 0; a < 2; a++)
        begin
            s3_p1_next[a] = s2_p1_reg[a];
            s3_p2_next[a] = s2_p2_reg[a];
            s3_pa_next[a] = PROD_W'(wa_reg) * PROD_W'(s2_d01_reg[a]);
            s3_pb_next[a] = PROD_W'(wb_reg) * PROD_W'(s2_d12_reg[a]);
            s3_pc_next[a] = PROD_W'(wc_reg) * PROD_W'(s2_d12_reg[a]);
            s3_pd_next[a] = PROD_W'(wd_reg) * PROD_W'(s2_d23_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_u_reg  <= s3_u_next;
            s3_u2_reg <= s3_u2_next;
            s3_u3_reg <= s3_u3_next;
            s3_p1_reg <= s3_p1_next;
            s3_p2_reg <= s3_p2_next;
            s3_pa_reg <= s3_pa_next;
            s3_pb_reg <= s3_pb_next;
            s3_pc_reg <= s3_pc_next;
            s3_pd_reg <= s3_pd_next;
        end
    end

    // stage 4: hermite basis in Q48 rounded to Q24, tangent sums rounded to Q16
    always_comb
    begin
        bas_u3 = signed'(BAS_W'(s3_u3_reg));
        bas_u2 = signed'(BAS_W'(s3_u2_reg)) <<< U_W;
        bas_u1 = signed'(BAS_W'(s3_u_reg)) <<< U2_W;
        bas_sum[0] = (bas_u3 <<< 1) - (bas_u2 <<< 1) - bas_u2 + BAS_ONE + BAS_HALF;
        bas_sum[1] = (bas_u2 <<< 1) + bas_u2 - (bas_u3 <<< 1) + BAS_HALF;
        bas_sum[2] = bas_u3 - (bas_u2 <<< 1) + bas_u1 + BAS_HALF;
        bas_sum[3] = bas_u3 - bas_u2 + BAS_HALF;
        for (int h = 0; h < 4; h++)
        begin
            s4_hb_next[h] = bas_sum[h][BASIS_SH +: HB_W];
        end
        for (int a = 0; a < 2; a++)
        begin
            s4_p1_next[a] = s3_p1_reg[a];
            s4_p2_next[a] = s3_p2_reg[a];
            g1_sum[a] = SUM_W'(s3_pa_reg[a]) + SUM_W'(s3_pb_reg[a]) + G_HALF;
            g2_sum[a] = SUM_W'(s3_pc_reg[a]) + SUM_W'(s3_pd_reg[a]) + G_HALF;
            s4_g1_next[a] = g1_sum[a][G_SH +: G_W];
            s4_g2_next[a] = g2_sum[a][G_SH +: G_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_hb_reg <= s4_hb_next;
            s4_p1_reg <= s4_p1_next;
            s4_p2_reg <= s4_p2_next;
            s4_g1_reg <= s4_g1_next;
            s4_g2_reg <= s4_g2_next;
        end
    end

    // stage 5: scale tangent sums by (1 - t)
    always_comb
    begin
        s5_hb_next = s4_hb_reg;
        for (int a = 0; a < 2; a++)
        begin
            s5_p1_next[a]  = s4_p1_reg[a];
            s5_p2_next[a]  = s4_p2_reg[a];
            s5_kg1_next[a] = KG_W'(k_reg) * KG_W'(s4_g1_reg[a]);
            s5_kg2_next[a] = KG_W'(k_reg) * KG_W'(s4_g2_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_hb_reg  <= s5_hb_next;
            s5_p1_reg  <= s5_p1_next;
            s5_p2_reg  <= s5_p2_next;
            s5_kg1_reg <= s5_kg1_next;
            s5_kg2_reg <= s5_kg2_next;
        end
    end

    // stage 6: round tangents (halving included), basis times points
    always_comb
    begin
        s6_hb2_next = s5_hb_reg[2];
        s6_hb3_next = s5_hb_reg[3];
        for (int a = 0; a < 2; a++)
        begin
            m1_sum[a] = s5_kg1_reg[a] + M_HALF;
            m2_sum[a] = s5_kg2_reg[a] + M_HALF;
            s6_m1_next[a]  = m1_sum[a][M_SH +: M_W];
            s6_m2_next[a]  = m2_sum[a][M_SH +: M_W];
            s6_pr0_next[a] = ACC_W'(s5_hb_reg[0]) * (ACC_W'(s5_p1_reg[a]) <<< 4);
            s6_pr1_next[a] = ACC_W'(s5_hb_reg[1]) * (ACC_W'(s5_p2_reg[a]) <<< 4);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_hb2_reg <= s6_hb2_next;
            s6_hb3_reg <= s6_hb3_next;
            s6_m1_reg  <= s6_m1_next;
            s6_m2_reg  <= s6_m2_next;
            s6_pr0_reg <= s6_pr0_next;
            s6_pr1_reg <= s6_pr1_next;
        end
    end

    // stage 7: basis times tangents
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            s7_pr_next[0][a] = s6_pr0_reg[a];
            s7_pr_next[1][a] = s6_pr1_reg[a];
            s7_pr_next[2][a] = ACC_W'(s6_hb2_reg) * ACC_W'(s6_m1_reg[a]);
            s7_pr_next[3][a] = ACC_W'(s6_hb3_reg) * ACC_W'(s6_m2_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_pr_reg <= s7_pr_next;
        end
    end

    // stage 8: accumulate with rounding offset
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            s8_acc_next[a] = s7_pr_reg[0][a] + s7_pr_reg[1][a]
                           + s7_pr_reg[2][a] + s7_pr_reg[3][a] + OUT_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s8_acc_reg <= s8_acc_next;
        end
    end

    // stage 9: drop to Q12 and saturate
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            q_val[a] = s8_acc_reg[a][OUT_SH +: Q_W];
            if (q_val[a] > SAT_MAX)
            begin
                s9_out_next[a] = SAT_MAX[COORD_W-1:0];
            end
            else if (q_val[a] < SAT_MIN)
            begin
                s9_out_next[a] = SAT_MIN[COORD_W-1:0];
            end
            else
            begin
                s9_out_next[a] = q_val[a][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            s9_out_reg <= s9_out_next;
        end
    end

endmodule
